// ===== rtl/p2a_pkg.sv =====
// Package for the pixel to ASCII downsampler: sizes, register codes and word types.
// Has no dependencies; every module of the block refers to it by scoped names.
package p2a_pkg;

  // Largest source dimension that the position counters cover.
  localparam int MAX_DIM = 4096;

  // Width of an effective dimension (holds MAX_DIM itself).
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  // Width of a source position index (0 .. MAX_DIM-1).
  localparam int IDX_W = $clog2(MAX_DIM);
  // Width of the target and position accumulators (up to 2*MAX_DIM*MAX_DIM).
  localparam int ACC_W = 2 * IDX_W + 2;

  // Configuration registers.
  localparam int CFG_W    = 13;
  localparam int EXT_W    = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int NUM_REGS = 4;
  localparam int REG_W    = $clog2(NUM_REGS);
  localparam int ADDR_W   = REG_W + 2;
  localparam int DATA_W   = 32;

  localparam logic [CFG_W-1:0] SRC_W_RST  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] SRC_H_RST  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] GRID_W_RST = CFG_W'(1024);
  localparam logic [CFG_W-1:0] GRID_H_RST = CFG_W'(512);

  // Queue between the selection front and the glyph back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register index codes (word address bits [3:2]).
  typedef enum logic [REG_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_GRID_WIDTH    = 2'd2,
    REG_GRID_HEIGHT   = 2'd3
  } reg_idx_e;

  // Raw configuration as written.
  typedef struct packed {
    logic [CFG_W-1:0] source_width;
    logic [CFG_W-1:0] source_height;
    logic [CFG_W-1:0] grid_width;
    logic [CFG_W-1:0] grid_height;
  } cfg_t;

  // One source pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One picked pixel waiting for its glyph.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } pick_t;

  // One grid cell.
  typedef struct packed {
    logic [6:0] glyph;
    logic [7:0] cell_red;
    logic [7:0] cell_green;
    logic [7:0] cell_blue;
    logic       row_end;
    logic       frame_end;
  } cell_t;

endpackage

// ===== rtl/pixel_to_ascii_downsampler.sv =====
// Top level of the pixel to ASCII downsampler: register port, front, queue and back end.
// Depends on p2a_pkg, p2a_front, p2a_queue and p2a_back.
//
//   Channel   Direction  Handshake                     Word
//   pixel     in         pixel_valid_i / pixel_stall_o  red, green, blue
//   cell      out        cell_valid_o / cell_stall_i    glyph, color, row_end, frame_end
//   config    in         psel, penable, pwrite, pready  four 13-bit size registers
//
// One pixel is taken every cycle while pixel_stall_o is low; the column target/position
// compare and add in the front sets the cycle. A picked pixel is written into the queue
// and then into the output register before it is on cell_o. Reset restores the default
// sizes and starts a new frame; any register write starts a new frame too. A stall on
// the cell side fills the two-word queue, and only then is pixel_stall_o raised.
module pixel_to_ascii_downsampler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pixel_valid_i,
  output logic                        pixel_stall_o,
  input  p2a_pkg::pixel_t             pixel_i,
  output logic                        cell_valid_o,
  input  logic                        cell_stall_i,
  output p2a_pkg::cell_t              cell_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [p2a_pkg::ADDR_W-1:0]  paddr,
  input  logic [p2a_pkg::DATA_W-1:0]  pwdata,
  output logic [p2a_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  p2a_pkg::cfg_t    cfg_q, cfg_d;
  p2a_pkg::reg_idx_e reg_idx;
  logic             cfg_wr;
  logic             push, queue_full, pop, head_valid;
  p2a_pkg::pick_t   push_data, head;

  // Register port: always ready, written in the access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = p2a_pkg::reg_idx_e'(paddr[p2a_pkg::ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        p2a_pkg::REG_SOURCE_WIDTH:  cfg_d.source_width  = pwdata[p2a_pkg::CFG_W-1:0];
        p2a_pkg::REG_SOURCE_HEIGHT: cfg_d.source_height = pwdata[p2a_pkg::CFG_W-1:0];
        p2a_pkg::REG_GRID_WIDTH:    cfg_d.grid_width    = pwdata[p2a_pkg::CFG_W-1:0];
        p2a_pkg::REG_GRID_HEIGHT:   cfg_d.grid_height   = pwdata[p2a_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back of the size registers.
  always_comb begin
    case (reg_idx)
      p2a_pkg::REG_SOURCE_WIDTH:  prdata = p2a_pkg::DATA_W'(cfg_q.source_width);
      p2a_pkg::REG_SOURCE_HEIGHT: prdata = p2a_pkg::DATA_W'(cfg_q.source_height);
      p2a_pkg::REG_GRID_WIDTH:    prdata = p2a_pkg::DATA_W'(cfg_q.grid_width);
      p2a_pkg::REG_GRID_HEIGHT:   prdata = p2a_pkg::DATA_W'(cfg_q.grid_height);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= p2a_pkg::SRC_W_RST;
      cfg_q.source_height <= p2a_pkg::SRC_H_RST;
      cfg_q.grid_width    <= p2a_pkg::GRID_W_RST;
      cfg_q.grid_height   <= p2a_pkg::GRID_H_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Selection front.
  p2a_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cfg_wr_i      (cfg_wr),
    .pixel_valid_i (pixel_valid_i),
    .pixel_stall_o (pixel_stall_o),
    .pixel_i       (pixel_i),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // Queue of picked pixels.
  p2a_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Glyph back end and output register.
  p2a_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .cell_valid_o (cell_valid_o),
    .cell_stall_i (cell_stall_i),
    .cell_o       (cell_o)
  );

endmodule

// ===== rtl/p2a_front.sv =====
// Selection front: tracks the source position and picks the nearest-neighbour pixels.
// Depends on p2a_pkg; pushes picked pixels into the p2a_queue.
module p2a_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  p2a_pkg::cfg_t  cfg_i,
  input  logic           cfg_wr_i,
  input  logic           pixel_valid_i,
  output logic           pixel_stall_o,
  input  p2a_pkg::pixel_t pixel_i,
  input  logic           queue_full_i,
  output logic           push_o,
  output p2a_pkg::pick_t push_data_o
);

  // Saturate a written size into 1 .. hi.
  function automatic logic [p2a_pkg::DIM_W-1:0] clamp_dim(
    input logic [p2a_pkg::CFG_W-1:0] v,
    input logic [p2a_pkg::DIM_W-1:0] hi
  );
    logic [p2a_pkg::EXT_W-1:0] ext;
    ext = p2a_pkg::EXT_W'(v);
    if (ext == '0) begin
      return p2a_pkg::DIM_W'(1);
    end else if (ext > p2a_pkg::EXT_W'(hi)) begin
      return hi;
    end else begin
      return p2a_pkg::DIM_W'(ext);
    end
  endfunction

  localparam logic [p2a_pkg::DIM_W-1:0] MaxDimV = p2a_pkg::DIM_W'(p2a_pkg::MAX_DIM);

  logic [p2a_pkg::DIM_W-1:0] w_eff, h_eff, gw_eff, gh_eff;

  // Position state. Targets hold 2*out*W, so the picked column is where
  // target + W falls below position + 2*GW.
  logic [p2a_pkg::IDX_W-1:0] in_col_q, in_col_d, in_row_q, in_row_d;
  logic [p2a_pkg::DIM_W-1:0] out_col_q, out_col_d, out_row_q, out_row_d;
  logic [p2a_pkg::ACC_W-1:0] col_tgt_q, col_tgt_d, col_pos_q, col_pos_d;
  logic [p2a_pkg::ACC_W-1:0] row_tgt_q, row_tgt_d, row_pos_q, row_pos_d;

  logic [p2a_pkg::ACC_W-1:0] w_acc2, h_acc2, gw_acc2, gh_acc2;
  logic col_pick, row_pick, last_col, last_row, accept;

  // Effective sizes: only downscaling is done.
  assign w_eff  = clamp_dim(cfg_i.source_width, MaxDimV);
  assign h_eff  = clamp_dim(cfg_i.source_height, MaxDimV);
  assign gw_eff = clamp_dim(cfg_i.grid_width, w_eff);
  assign gh_eff = clamp_dim(cfg_i.grid_height, h_eff);

  assign w_acc2  = p2a_pkg::ACC_W'({w_eff, 1'b0});
  assign h_acc2  = p2a_pkg::ACC_W'({h_eff, 1'b0});
  assign gw_acc2 = p2a_pkg::ACC_W'({gw_eff, 1'b0});
  assign gh_acc2 = p2a_pkg::ACC_W'({gh_eff, 1'b0});

  // Pick decisions for the current pixel.
  assign col_pick = (out_col_q < gw_eff) &&
                    ((col_tgt_q + p2a_pkg::ACC_W'(w_eff)) < (col_pos_q + gw_acc2));
  assign row_pick = (out_row_q < gh_eff) &&
                    ((row_tgt_q + p2a_pkg::ACC_W'(h_eff)) < (row_pos_q + gh_acc2));

  assign last_col = (p2a_pkg::DIM_W'(in_col_q) + p2a_pkg::DIM_W'(1)) >= w_eff;
  assign last_row = (p2a_pkg::DIM_W'(in_row_q) + p2a_pkg::DIM_W'(1)) >= h_eff;

  assign accept        = pixel_valid_i && !queue_full_i;
  assign pixel_stall_o = queue_full_i;

  // Word pushed into the queue for a picked pixel.
  assign push_o                = accept && row_pick && col_pick;
  assign push_data_o.red       = pixel_i.red;
  assign push_data_o.green     = pixel_i.green;
  assign push_data_o.blue      = pixel_i.blue;
  assign push_data_o.row_end   = (out_col_q == (gw_eff - p2a_pkg::DIM_W'(1)));
  assign push_data_o.frame_end = (out_col_q == (gw_eff - p2a_pkg::DIM_W'(1))) &&
                                 (out_row_q == (gh_eff - p2a_pkg::DIM_W'(1)));

  // Next position state.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    col_tgt_d = col_tgt_q;
    col_pos_d = col_pos_q;
    row_tgt_d = row_tgt_q;
    row_pos_d = row_pos_q;
    if (cfg_wr_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      col_tgt_d = '0;
      col_pos_d = '0;
      row_tgt_d = '0;
      row_pos_d = '0;
    end else if (accept) begin
      if (col_pick) begin
        col_tgt_d = col_tgt_q + w_acc2;
        out_col_d = out_col_q + p2a_pkg::DIM_W'(1);
      end
      col_pos_d = col_pos_q + gw_acc2;
      if (last_col) begin
        in_col_d  = '0;
        out_col_d = '0;
        col_tgt_d = '0;
        col_pos_d = '0;
        if (last_row) begin
          in_row_d  = '0;
          out_row_d = '0;
          row_tgt_d = '0;
          row_pos_d = '0;
        end else begin
          if (row_pick) begin
            row_tgt_d = row_tgt_q + h_acc2;
            out_row_d = out_row_q + p2a_pkg::DIM_W'(1);
          end
          row_pos_d = row_pos_q + gh_acc2;
          in_row_d  = in_row_q + p2a_pkg::IDX_W'(1);
        end
      end else begin
        in_col_d = in_col_q + p2a_pkg::IDX_W'(1);
      end
    end
  end

  // Position registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      col_tgt_q <= '0;
      col_pos_q <= '0;
      row_tgt_q <= '0;
      row_pos_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      col_tgt_q <= col_tgt_d;
      col_pos_q <= col_pos_d;
      row_tgt_q <= row_tgt_d;
      row_pos_q <= row_pos_d;
    end
  end

  // A register write starts a new frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_i |=> (in_col_q == '0 && in_row_q == '0 && out_col_q == '0 &&
                  col_tgt_q == '0 && row_pos_q == '0))
    else $error("frame not restarted after a register write");

  // The grid column never runs past the grid width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_col_q <= gw_eff)
    else $error("grid column beyond grid width");

  // The grid row never runs past the grid height.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q <= gh_eff)
    else $error("grid row beyond grid height");

endmodule

// ===== rtl/p2a_queue.sv =====
// Short queue of picked pixels between the selection front and the glyph back end.
// Depends on p2a_pkg for its depth and word type.
module p2a_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  p2a_pkg::pick_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output p2a_pkg::pick_t head_o
);

  p2a_pkg::pick_t entry_q [p2a_pkg::QUEUE_DEPTH];

  logic [p2a_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [p2a_pkg::QCNT_W-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o       = (count_q == p2a_pkg::QCNT_W'(p2a_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      if (wr_ptr_q == p2a_pkg::QPTR_W'(p2a_pkg::QUEUE_DEPTH - 1)) begin
        wr_ptr_d = '0;
      end else begin
        wr_ptr_d = wr_ptr_q + p2a_pkg::QPTR_W'(1);
      end
    end
    if (do_pop) begin
      if (rd_ptr_q == p2a_pkg::QPTR_W'(p2a_pkg::QUEUE_DEPTH - 1)) begin
        rd_ptr_d = '0;
      end else begin
        rd_ptr_d = rd_ptr_q + p2a_pkg::QPTR_W'(1);
      end
    end
    if (do_push && !do_pop) begin
      count_d = count_q + p2a_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - p2a_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage words carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill count stays within the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= p2a_pkg::QCNT_W'(p2a_pkg::QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  // The front never pushes into a full queue, so no word is dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  // The back end only pops when a word is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from an empty queue");

endmodule

// ===== rtl/p2a_back.sv =====
// Glyph back end: maps a picked pixel's brightness to a ramp character and holds the output word.
// Depends on p2a_pkg; pops words from the p2a_queue.
module p2a_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  p2a_pkg::pick_t head_i,
  output logic           pop_o,
  output logic           cell_valid_o,
  input  logic           cell_stall_i,
  output p2a_pkg::cell_t cell_o
);

  // Ramp from dark to light.
  localparam logic [6:0] Ramp [10] = '{
    7'd64, 7'd37, 7'd35, 7'd42, 7'd43, 7'd61, 7'd45, 7'd58, 7'd46, 7'd32
  };

  // Index k is reached when gray >= ceil(255k/9); gray = floor(sum/3), so the
  // bound on the channel sum is three times that.
  localparam logic [9:0] SumBound [9] = '{
    10'd87, 10'd171, 10'd255, 10'd342, 10'd426, 10'd510, 10'd597, 10'd681, 10'd765
  };

  logic [9:0] sum;
  logic [3:0] idx;
  logic       out_valid_q, out_valid_d;
  p2a_pkg::cell_t out_q, out_d;

  assign sum = 10'(head_i.red) + 10'(head_i.green) + 10'(head_i.blue);

  // Count the brightness bounds passed; this is the ramp index.
  always_comb begin
    idx = '0;
    for (int k = 0; k < 9; k++) begin
      idx = idx + 4'(sum >= SumBound[k]);
    end
  end

  // Load the output register when it is empty or being taken.
  assign pop_o = head_valid_i && (!out_valid_q || !cell_stall_i);

  always_comb begin
    out_d.glyph      = Ramp[idx];
    out_d.cell_red   = head_i.red;
    out_d.cell_green = head_i.green;
    out_d.cell_blue  = head_i.blue;
    out_d.row_end    = head_i.row_end;
    out_d.frame_end  = head_i.frame_end;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!cell_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign cell_valid_o = out_valid_q;
  assign cell_o       = out_q;

  // The last cell of the grid is also the last cell of its row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid_o && cell_o.frame_end) |-> cell_o.row_end)
    else $error("frame end without row end");

  // A stalled word stays on the output unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid_o && cell_stall_i) |=> (cell_valid_o && $stable(cell_o)))
    else $error("output word changed under stall");

  // Every glyph is a printable character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid_o |-> (cell_o.glyph >= 7'd32 && cell_o.glyph <= 7'd126))
    else $error("glyph outside the printable range");

endmodule

// ===== tb/pixel_to_ascii_downsampler_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pixel_to_ascii_downsampler: streams pixel words, writes the
// size registers over the APB port and checks every grid cell word against a prediction.
// Depends on p2a_pkg and the pixel_to_ascii_downsampler RTL.

module pixel_to_ascii_downsampler_test;

  localparam int HALF_PERIOD  = 10;
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int SETTLE       = 8;
  localparam int DRAIN_LIMIT  = 1000;
  localparam int PRINT_LIMIT  = 50;

  // Glyph ramp from dark to light, as ASCII codes.
  localparam byte GLYPH_RAMP [10] = '{"@", "%", "#", "*", "+", "=", "-", ":", ".", " "};
  // Gray levels that land on each ramp step in turn.
  localparam logic [7:0] GRAY_STEPS [10] = '{8'd0, 8'd29, 8'd57, 8'd85, 8'd114,
                                            8'd142, 8'd170, 8'd199, 8'd227, 8'd255};

  // Predicts the cell words from accepted pixel words and checks the outputs in order.
  class cell_scoreboard;
    logic [p2a_pkg::CFG_W-1:0] src_w, src_h, grid_w, grid_h;
    logic [p2a_pkg::DIM_W-1:0] in_col, in_row, out_col, out_row;
    logic [p2a_pkg::ACC_W-1:0] col_target, col_pos, row_target, row_pos;
    p2a_pkg::cell_t            expected_cells[$];
    int                        mismatches;
    int                        cells_seen;

    function new();
      src_w      = p2a_pkg::SRC_W_RST;
      src_h      = p2a_pkg::SRC_H_RST;
      grid_w     = p2a_pkg::GRID_W_RST;
      grid_h     = p2a_pkg::GRID_H_RST;
      mismatches = 0;
      cells_seen = 0;
      restart_frame();
    endfunction

    function int unsigned fit(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Effective sizes: the grid never exceeds the source, the source never MAX_DIM.
    function void sizes(output int unsigned w, h, gw, gh);
      w  = fit(32'(src_w), p2a_pkg::MAX_DIM);
      h  = fit(32'(src_h), p2a_pkg::MAX_DIM);
      gw = fit(32'(grid_w), w);
      gh = fit(32'(grid_h), h);
    endfunction

    function void restart_row();
      int unsigned w, h, gw, gh;
      sizes(w, h, gw, gh);
      in_col     = '0;
      out_col    = '0;
      col_target = p2a_pkg::ACC_W'(w);
      col_pos    = '0;
    endfunction

    function void restart_frame();
      int unsigned w, h, gw, gh;
      sizes(w, h, gw, gh);
      restart_row();
      in_row     = '0;
      out_row    = '0;
      row_target = p2a_pkg::ACC_W'(h);
      row_pos    = '0;
    endfunction

    // Any register write starts a new frame with the new sizes.
    function void write_size(p2a_pkg::reg_idx_e idx, logic [p2a_pkg::DATA_W-1:0] data);
      case (idx)
        p2a_pkg::REG_SOURCE_WIDTH: begin
          src_w = data[p2a_pkg::CFG_W-1:0];
        end
        p2a_pkg::REG_SOURCE_HEIGHT: begin
          src_h = data[p2a_pkg::CFG_W-1:0];
        end
        p2a_pkg::REG_GRID_WIDTH: begin
          grid_w = data[p2a_pkg::CFG_W-1:0];
        end
        p2a_pkg::REG_GRID_HEIGHT: begin
          grid_h = data[p2a_pkg::CFG_W-1:0];
        end
        default: ;
      endcase
      restart_frame();
    endfunction

    // Advances the sampling position by one pixel and queues the cell it picks, if any.
    function void note_pixel(p2a_pkg::pixel_t px);
      int unsigned    w, h, gw, gh, shade;
      bit             row_pick, col_pick;
      p2a_pkg::cell_t next_cell;
      sizes(w, h, gw, gh);
      row_pick = (out_row < gh) && (row_target < row_pos + 2 * gh);
      col_pick = (out_col < gw) && (col_target < col_pos + 2 * gw);

      if (row_pick && col_pick) begin
        shade                = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
        next_cell.glyph      = GLYPH_RAMP[shade * 9 / 255][6:0];
        next_cell.cell_red   = px.red;
        next_cell.cell_green = px.green;
        next_cell.cell_blue  = px.blue;
        next_cell.row_end    = (out_col == gw - 1);
        next_cell.frame_end  = (out_col == gw - 1) && (out_row == gh - 1);
        expected_cells       = {expected_cells, next_cell};
      end

      // Column accumulators move every pixel; the target only moves on a pick.
      if (col_pick) begin
        col_target += p2a_pkg::ACC_W'(2 * w);
        out_col++;
      end
      col_pos += p2a_pkg::ACC_W'(2 * gw);

      // At the end of a source row, step the row accumulators or wrap the frame.
      if (in_col + 1 >= w) begin
        if (in_row + 1 >= h) begin
          restart_frame();
        end else begin
          if (row_pick) begin
            row_target += p2a_pkg::ACC_W'(2 * h);
            out_row++;
          end
          row_pos += p2a_pkg::ACC_W'(2 * gh);
          in_row++;
          restart_row();
        end
      end else begin
        in_col++;
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
        $display("[%0t] cell word %0d: %s got %0d, expected %0d",
                 $time, cells_seen, what, got, want);
      end
    endtask

    // Compares one accepted cell word with the oldest prediction, field by field.
    task check_cell(p2a_pkg::cell_t got);
      p2a_pkg::cell_t want;
      cells_seen++;
      if (expected_cells.size() == 0) begin
        report("unexpected word, glyph", 32'(got.glyph), 0);
        return;
      end
      want = expected_cells.pop_front();
      if (got.glyph !== want.glyph) report("glyph", 32'(got.glyph), 32'(want.glyph));
      if (got.cell_red !== want.cell_red) begin
        report("cell_red", 32'(got.cell_red), 32'(want.cell_red));
      end
      if (got.cell_green !== want.cell_green) begin
        report("cell_green", 32'(got.cell_green), 32'(want.cell_green));
      end
      if (got.cell_blue !== want.cell_blue) begin
        report("cell_blue", 32'(got.cell_blue), 32'(want.cell_blue));
      end
      if (got.row_end !== want.row_end) begin
        report("row_end", 32'(got.row_end), 32'(want.row_end));
      end
      if (got.frame_end !== want.frame_end) begin
        report("frame_end", 32'(got.frame_end), 32'(want.frame_end));
      end
    endtask
  endclass

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         pixel_valid_i = 1'b0;
  logic                         pixel_stall_o;
  p2a_pkg::pixel_t              pixel_i       = '0;
  logic                         cell_valid_o;
  logic                         cell_stall_i  = 1'b0;
  p2a_pkg::cell_t               cell_o;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [p2a_pkg::ADDR_W-1:0]   paddr         = '0;
  logic [p2a_pkg::DATA_W-1:0]   pwdata        = '0;
  logic [p2a_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  cell_scoreboard               sb;
  bit                           idle_on       = 1'b1;
  int unsigned                  cycle_count   = 0;

  pixel_to_ascii_downsampler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_valid_i (pixel_valid_i),
    .pixel_stall_o (pixel_stall_o),
    .pixel_i       (pixel_i),
    .cell_valid_o  (cell_valid_o),
    .cell_stall_i  (cell_stall_i),
    .cell_o        (cell_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** pixel_to_ascii_downsampler: FAILED **");
      $finish;
    end
  end

  // Every accepted cell word goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && cell_valid_o && !cell_stall_i) sb.check_cell(cell_o);
  end

  // Receiver back-pressure comes in random bursts while idling is enabled.
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        cell_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        cell_stall_i <= 1'b0;
      end
    end
  end

  // Offers one pixel word, sometimes after a gap, and waits until it is taken.
  task automatic send_pixel(input p2a_pkg::pixel_t px);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pixel_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_i       <= px;
    do @(posedge clk_i); while (pixel_stall_o);
    sb.note_pixel(px);
  endtask

  task automatic send_random(input int unsigned count);
    logic [23:0] bits;
    for (int i = 0; i < count; i++) begin
      bits = 24'($urandom);
      send_pixel(bits);
    end
  endtask

  // One APB transfer: setup phase, then access phase until pready.
  task automatic apb_access(input logic write, input p2a_pkg::reg_idx_e idx,
                            input logic [p2a_pkg::DATA_W-1:0] wdata,
                            output logic [p2a_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops the pixel stream and waits for the predicted cells to come out.
  task automatic wait_idle();
    pixel_valid_i <= 1'b0;
    for (int t = 0; t < DRAIN_LIMIT && sb.expected_cells.size() != 0; t++) begin
      @(posedge clk_i);
    end
    if (sb.expected_cells.size() != 0) begin
      sb.report("missing words", 0, sb.expected_cells.size());
      sb.expected_cells.delete();
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes all four size registers once the block is idle and reads each one back.
  task automatic apply_sizes(input int unsigned sw, sh, gw, gh);
    int unsigned                vals [4];
    logic [p2a_pkg::DATA_W-1:0] data, back;
    p2a_pkg::reg_idx_e          idx;
    vals = '{sw, sh, gw, gh};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      idx  = p2a_pkg::reg_idx_e'(i);
      data = $urandom;
      data[p2a_pkg::CFG_W-1:0] = p2a_pkg::CFG_W'(vals[i]);
      apb_access(1'b1, idx, data, back);
      sb.write_size(idx, data);
      apb_access(1'b0, idx, '0, back);
      if (back[p2a_pkg::CFG_W-1:0] !== data[p2a_pkg::CFG_W-1:0]) begin
        sb.report("register readback", 32'(back[p2a_pkg::CFG_W-1:0]),
                  32'(data[p2a_pkg::CFG_W-1:0]));
      end
    end
  endtask

  initial begin
    int unsigned w, h;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default sizes: source row 0 is not picked, so these words give no cell.
    send_pixel({8'd0, 8'd0, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd255, 8'd0, 8'd0});

    // One to one grid: every pixel is a cell, walking the whole glyph ramp.
    apply_sizes(5, 2, 5, 2);
    for (int i = 0; i < 10; i++) send_pixel({GRAY_STEPS[i], GRAY_STEPS[i], GRAY_STEPS[i]});

    // Single cell from the middle of a three pixel row, across a frame wrap.
    apply_sizes(3, 1, 1, 1);
    send_pixel({8'd255, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd255, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd255});
    send_pixel({8'd0, 8'd255, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd255});
    send_pixel({8'd255, 8'd255, 8'd0});

    // Zero sizes saturate to a one by one frame.
    apply_sizes(0, 0, 0, 0);
    send_pixel({8'd1, 8'd2, 8'd3});
    send_pixel({8'd128, 8'd64, 8'd32});
    send_pixel({8'd255, 8'd255, 8'd254});

    // Small random frames, grid sizes from zero up past the source size.
    for (int ph = 0; ph < 24; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 10);
      if (ph % 8 == 3) w = 0;
      if (ph % 8 == 5) h = 0;
      apply_sizes(w, h, $urandom_range(0, w + 2), $urandom_range(0, h + 2));
      send_random($urandom_range(20, 52));
    end

    // Largest sizes: the start of a saturated row, then two tall single column frames.
    idle_on = 1'b1;
    apply_sizes(8191, 1, 4095, 8191);
    send_random(300);
    apply_sizes(4096, 4096, 0, 4096);
    send_random(40);
    apply_sizes(1, 4096, 0, $urandom_range(2, 4096));
    send_random(200);

    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    w = $urandom_range(2, 16);
    h = $urandom_range(2, 8);
    apply_sizes(w, h, $urandom_range(1, w), $urandom_range(1, h));
    send_random(120);

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("** pixel_to_ascii_downsampler: PASSED **");
    end else begin
      $display("** pixel_to_ascii_downsampler: FAILED **");
    end
    $finish;
  end

endmodule
